### rtl/usan_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usan_pkg
// Shared types, constants and byte-classification functions of the UTF-8
// stream sanitiser.
// ----------------------------------------------------------------------------
package usan_pkg;

    // Window, queue and burst sizes
    localparam int unsigned WIN_DEPTH   = 3;
    localparam int unsigned MAX_PUSH    = WIN_DEPTH + 1;
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PUSH_W      = $clog2(MAX_PUSH + 1);

    // Register map (index = byte address / 4)
    localparam logic REG_REPLACEMENT = 1'b0;
    localparam logic [7:0] REPLACEMENT_RESET = 8'h3F;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    // Output transfer payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_replaced;
        logic       out_last;
    } t_out_item;

    // Burst of results handed from the front end to the queue
    typedef struct packed {
        logic [PUSH_W-1:0]               cnt;
        t_out_item [MAX_PUSH-1:0]        items;
    } t_push;

    // Lead class: the code of a multi-byte lead is its number of followers
    typedef enum logic [2:0] {
        LC_ASCII = 3'd0,
        LC_TWO   = 3'd1,
        LC_THREE = 3'd2,
        LC_FOUR  = 3'd3,
        LC_BAD   = 3'd4
    } t_lead_class;

    function automatic t_lead_class lead_class(input logic [7:0] b);
        t_lead_class c;
        if (b <= 8'h7F) begin
            c = LC_ASCII;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            c = LC_TWO;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            c = LC_THREE;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            c = LC_FOUR;
        end else begin
            c = LC_BAD;
        end
        return c;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // Check a complete sequence: followers, overlong forms, surrogates, range
    function automatic logic seq_ok(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3,
                                    input t_lead_class c);
        logic ok;
        case (c)
            LC_TWO: begin
                ok = is_cont(b1);
            end
            LC_THREE: begin
                ok = is_cont(b1) && is_cont(b2)
                     && !(b0 == 8'hE0 && b1 < 8'hA0)
                     && !(b0 == 8'hED && b1 >= 8'hA0);
            end
            LC_FOUR: begin
                ok = is_cont(b1) && is_cont(b2) && is_cont(b3)
                     && !(b0 == 8'hF0 && b1 < 8'h90)
                     && !(b0 == 8'hF4 && b1 >= 8'h90);
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        return ok;
    endfunction

endpackage
`default_nettype wire

### rtl/usan_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usan_front
// Window of held-back bytes and the classifier: resolves the window plus the
// incoming byte into a burst of up to four results, combinationally.
// ----------------------------------------------------------------------------
module usan_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire usan_pkg::t_in_item i_in_item,
    input  wire logic              i_space_ok,
    input  wire logic [7:0]        i_repl,
    output usan_pkg::t_push        o_push
);
    import usan_pkg::*;

    localparam int unsigned BUF_N = 2 * WIN_DEPTH + 1;

    logic [7:0]  r_pend [WIN_DEPTH];
    logic [1:0]  r_cnt;
    logic [7:0]  n_pend [WIN_DEPTH];
    logic [1:0]  n_cnt;

    logic              w_accept;
    logic [7:0]        w_buf [BUF_N];
    logic [2:0]        w_n;
    t_lead_class       w_cls [MAX_PUSH];
    logic [MAX_PUSH-1:0] w_ok;
    logic [MAX_PUSH-1:0] w_emit;
    logic [MAX_PUSH-1:0] w_repl;
    logic              w_stop;
    logic [2:0]        w_stop_pos;
    t_lead_class       w_head_cls;

    assign o_in_ready = i_space_ok;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_n        = {1'b0, r_cnt} + 3'd1;
    assign w_head_cls = lead_class(r_pend[0]);

    // Line up the held bytes and the new byte, zero padded past the end
    always_comb begin
        for (int i = 0; i < BUF_N; i++) begin
            w_buf[i] = 8'h00;
        end
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if (2'(i) < r_cnt) begin
                w_buf[i] = r_pend[i];
            end
        end
        w_buf[{1'b0, r_cnt}] = i_in_item.in_byte;
    end

    // Classify every position as a possible lead
    always_comb begin
        for (int p = 0; p < MAX_PUSH; p++) begin
            w_cls[p] = lead_class(w_buf[p]);
            w_ok[p]  = seq_ok(w_buf[p], w_buf[p+1], w_buf[p+2], w_buf[p+3], w_cls[p]);
        end
    end

    // Walk: pass valid sequences, replace bad leads, hold short tail if not last
    always_comb begin
        logic [1:0] rem;
        logic [2:0] need;
        logic [2:0] avail;
        rem        = 2'd0;
        w_stop     = 1'b0;
        w_stop_pos = w_n;
        w_emit     = '0;
        w_repl     = '0;
        for (int p = 0; p < MAX_PUSH; p++) begin
            need  = {1'b0, w_cls[p][1:0]} + 3'd1;
            avail = w_n - 3'(p);
            if (!w_stop && 3'(p) < w_n) begin
                if (rem != 2'd0) begin
                    w_emit[p] = 1'b1;
                    rem       = rem - 2'd1;
                end else begin
                    case (w_cls[p])
                        LC_ASCII: begin
                            w_emit[p] = 1'b1;
                        end
                        LC_BAD: begin
                            w_emit[p] = 1'b1;
                            w_repl[p] = 1'b1;
                        end
                        default: begin
                            if (avail < need) begin
                                if (!i_in_item.in_last) begin
                                    w_stop     = 1'b1;
                                    w_stop_pos = 3'(p);
                                end else begin
                                    w_emit[p] = 1'b1;
                                    w_repl[p] = 1'b1;
                                end
                            end else if (w_ok[p]) begin
                                w_emit[p] = 1'b1;
                                rem       = w_cls[p][1:0];
                            end else begin
                                w_emit[p] = 1'b1;
                                w_repl[p] = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Build the burst for the queue
    always_comb begin
        o_push.cnt = w_accept ? w_stop_pos : '0;
        for (int p = 0; p < MAX_PUSH; p++) begin
            o_push.items[p].out_byte     = w_repl[p] ? i_repl : w_buf[p];
            o_push.items[p].out_replaced = w_repl[p];
            o_push.items[p].out_last     = i_in_item.in_last
                                           && (3'(p) + 3'd1 == w_stop_pos);
        end
    end

    // Keep the unresolved tail of the window
    always_comb begin
        for (int j = 0; j < WIN_DEPTH; j++) begin
            n_pend[j] = w_buf[w_stop_pos + 3'(j)];
        end
        n_cnt = w_stop ? 2'(w_n - w_stop_pos) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            for (int j = 0; j < WIN_DEPTH; j++) begin
                r_pend[j] <= 8'h00;
            end
        end else if (w_accept) begin
            r_cnt <= n_cnt;
            for (int j = 0; j < WIN_DEPTH; j++) begin
                r_pend[j] <= n_pend[j];
            end
        end
    end

    // The end of a buffer empties the window
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_item.in_last |=> r_cnt == 2'd0)
        else $error("window not empty after last byte");

    // A held window always starts with a multi-byte lead
    a_head_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd0 |-> (w_head_cls == LC_TWO || w_head_cls == LC_THREE
                           || w_head_cls == LC_FOUR))
        else $error("held window does not start with a lead");

    // Bytes in equal bytes out plus the change in held bytes
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ({1'b0, o_push.cnt} + {2'b00, n_cnt} == {1'b0, w_n}))
        else $error("byte count mismatch in window walk");

    // Emitted positions form an unbroken run from the front of the window
    a_emit_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (w_emit == MAX_PUSH'((5'd1 << o_push.cnt) - 5'd1)))
        else $error("gap in emitted window positions");

endmodule
`default_nettype wire

### rtl/usan_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usan_queue
// Short result queue between front and back end: takes a burst of up to four
// entries per cycle, releases one per cycle while popped.
// ----------------------------------------------------------------------------
module usan_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire usan_pkg::t_push   i_push,
    input  wire logic              i_pop,
    output usan_pkg::t_out_item    o_head,
    output logic                   o_empty,
    output logic                   o_space_ok
);
    import usan_pkg::*;

    t_out_item            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_wr;
    logic [QPTR_W-1:0]    r_rd;
    logic [QCNT_W-1:0]    r_cnt;

    assign o_head     = r_mem[r_rd];
    assign o_empty    = r_cnt == '0;
    assign o_space_ok = r_cnt <= QCNT_W'(QUEUE_DEPTH - MAX_PUSH);

    // Store the burst at consecutive slots
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (PUSH_W'(i) < i_push.cnt) begin
                r_mem[QPTR_W'(r_wr + QPTR_W'(i))] <= i_push.items[i];
            end
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= QPTR_W'(r_wr + QPTR_W'(i_push.cnt));
            r_rd  <= QPTR_W'(r_rd + QPTR_W'(i_pop));
            r_cnt <= QCNT_W'(r_cnt + QCNT_W'(i_push.cnt) - QCNT_W'(i_pop));
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty result queue");

    a_burst_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt != '0 |-> o_space_ok)
        else $error("burst written without room");

endmodule
`default_nettype wire

### rtl/usan_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usan_back
// Output register: pulls one result per cycle from the queue while free or
// draining and holds it on the output channel until the receiver takes it.
// ----------------------------------------------------------------------------
module usan_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire usan_pkg::t_out_item i_head,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output usan_pkg::t_out_item    o_out_item
);
    import usan_pkg::*;

    logic      r_valid;
    t_out_item r_item;
    logic      w_take;

    assign w_take      = !r_valid || i_out_ready;
    assign o_pop       = w_take && !i_empty;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    // Load the next result when the register is free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
    end

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped result not presented");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_out_ready && i_empty |=> !r_valid)
        else $error("stale result presented twice");

    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_out_ready |-> !o_pop)
        else $error("result lost under output stall");

endmodule
`default_nettype wire

### rtl/utf8_stream_sanitizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer
// Byte stream UTF-8 checker that replaces invalid lead bytes.
//
// Input channel: one byte per transfer with a last-of-buffer flag. Output
// channel: the same bytes in order, each with a replaced flag; a lead byte
// that does not open a valid sequence goes out as the replacement byte.
// A multi-byte lead is held, with up to three bytes in all, until its
// sequence is complete; the last flag resolves and empties the window and
// marks the final output byte of that transfer.
// Throughput: one input byte per cycle while the result queue has room; a
// completed sequence passes through the queue memory and then the output
// register. The eight-entry result queue takes a burst of up to four
// results per cycle; input is taken while at least four entries are free.
// Output stalls fill the queue and then stop the input; nothing is lost.
// Reset empties window and queue and sets the replacement byte to '?'.
// APB register 0 (address 0): replacement byte, bits 7:0; write only while
// the block is idle.
// ----------------------------------------------------------------------------
module utf8_stream_sanitizer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire usan_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output usan_pkg::t_out_item    o_out_item,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import usan_pkg::*;

    logic [7:0] r_repl;
    logic       w_cfg_wr;
    t_push      w_push;
    logic       w_space_ok;
    logic       w_pop;
    logic       w_empty;
    t_out_item  w_head;

    // Configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_REPLACEMENT) ? {24'h000000, r_repl} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= REPLACEMENT_RESET;
        end else if (w_cfg_wr && paddr[2] == REG_REPLACEMENT) begin
            r_repl <= pwdata[7:0];
        end
    end

    usan_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_space_ok (w_space_ok),
        .i_repl     (r_repl),
        .o_push     (w_push)
    );

    usan_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_empty    (w_empty),
        .o_space_ok (w_space_ok)
    );

    usan_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire
